[rtl/socc_pkg.sv]
// Package for the self-organizing color cache.
// Holds shared widths, the key mask, entry, control and result types.
// No dependencies.
package socc_pkg;

  localparam int unsigned CacheSlotsDef = 16;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned ColorW        = 64;
  localparam int unsigned PosW          = 4;

  localparam logic [KeyW-1:0] WinByteMask = 32'hff00_0000;
  localparam logic [1:0]      KindFg      = 2'd1;

  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [ColorW-1:0] color;
  } entry_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cmp_en;  // capture the compare against the request key
    logic upd;     // apply swap or shift
    logic hit;     // the registered compare found the key
    logic ins;     // miss with insert: shift everything back
  } ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [PosW-1:0]   position;
    logic [ColorW-1:0] color_out;
    logic              inserted;
    logic              dropped;
    logic [ColorW-1:0] dropped_color;
  } res_t;

endpackage

[rtl/self_organizing_color_cache_top.sv]
// Top level of the self-organizing color cache (transpose on hit).
// Instantiates the cell row and the result encoder. Depends on socc_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------------
//   request | in        | in_valid_i / in_ready_o   | command, kind, fg/bg, modes, value
//   result  | out       | out_valid_o / out_ready_i | hit, position, colors, insert/drop flags
//
// A transaction first has every cell compare its key against the request
// key and register the match; then the row swaps or shifts and the result
// lands in the output register. One transaction is at work at a time, so a
// new request is not taken until the last one's update is done; a waiting
// result does not block the next request's compare, but its update holds
// until the output register frees. Reset clears all valid bits at once; no sweep.
module self_organizing_color_cache_top import socc_pkg::*; #(
  parameter int unsigned CACHE_SLOTS = CacheSlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [1:0]        kind_i,
  input  logic [31:0]       fg_color_i,
  input  logic [31:0]       bg_color_i,
  input  logic [15:0]       attr_mode_i,
  input  logic [7:0]        win_mode_i,
  input  logic [63:0]       color_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [3:0]        position_o,
  output logic [63:0]       color_out_o,
  output logic              inserted_o,
  output logic              dropped_o,
  output logic [63:0]       dropped_color_o
);

  logic              busy_q, busy_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              advance;
  logic [KeyW-1:0]   key;
  logic [KeyW-1:0]   req_key_q;
  logic [ColorW-1:0] req_value_q;
  logic              req_cmd_q;
  res_t              res;
  res_t              res_q;
  ctrl_t             ctrl;
  entry_t            new_ent;
  entry_t            ent [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0] match;
  logic [CACHE_SLOTS-1:0] vld;

  // Build the key: win byte on top, kind at 17..16, attr from bit 8, color index.
  assign key = ({win_mode_i, 24'd0} & WinByteMask)
             | {14'd0, kind_i, 16'd0}
             | {8'd0, attr_mode_i, 8'd0}
             | ((kind_i == KindFg) ? fg_color_i : bg_color_i);

  // Hold one transaction in flight; advance its update only when the result
  // has somewhere to go.
  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign advance    = busy_q && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (advance) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch the request for the update cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_key_q   <= key;
      req_value_q <= color_value_i;
      req_cmd_q   <= command_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign ctrl = '{cmp_en: accept, upd: advance, hit: res.hit, ins: res.inserted};
  assign new_ent = '{valid: 1'b1, key: req_key_q, color: req_value_q};

  // Cell row: each cell talks only to its two neighbors.
  for (genvar i = 0; i < CACHE_SLOTS; i++) begin : g_cell
    entry_t prev_w;
    entry_t next_w;
    logic   next_match_w;

    if (i == 0) begin : g_front
      assign prev_w = new_ent;
    end else begin : g_mid
      assign prev_w = ent[i-1];
    end

    if (i == CACHE_SLOTS - 1) begin : g_back
      assign next_w       = '0;
      assign next_match_w = 1'b0;
    end else begin : g_fwd
      assign next_w       = ent[i+1];
      assign next_match_w = match[i+1];
    end

    socc_cell #(
      .FRONT (i == 0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .req_key_i    (key),
      .prev_i       (prev_w),
      .next_i       (next_w),
      .next_match_i (next_match_w),
      .ent_o        (ent[i]),
      .match_o      (match[i])
    );

    assign vld[i] = ent[i].valid;
  end

  socc_result #(
    .CACHE_SLOTS (CACHE_SLOTS)
  ) u_result (
    .match_i (match),
    .ent_i   (ent),
    .cmd_i   (req_cmd_q),
    .value_i (req_value_q),
    .res_o   (res)
  );

  assign out_valid_o     = out_valid_q;
  assign hit_o           = res_q.hit;
  assign position_o      = res_q.position;
  assign color_out_o     = res_q.color_out;
  assign inserted_o      = res_q.inserted;
  assign dropped_o       = res_q.dropped;
  assign dropped_color_o = res_q.dropped_color;

  // Keys stay unique, so at most one cell matches.
  a_match_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(match))
    else $error("more than one cell matched the request key");

  // Valid cells form a solid run from the front.
  a_valid_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld & (vld + CACHE_SLOTS'(1))) == '0)
    else $error("valid cells are not contiguous from the front");

  a_hit_no_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && inserted_o) && (!dropped_o || inserted_o))
    else $error("result flags are inconsistent");

  a_advance_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && !busy_q)
    else $error("update did not produce a result");

endmodule

[rtl/socc_cell.sv]
// One cache cell: holds an entry and a registered compare result.
// Swaps or shifts with its neighbors on update. Depends on socc_pkg.
module socc_cell import socc_pkg::*; #(
  parameter bit FRONT = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_t           ctrl_i,
  input  logic [KeyW-1:0] req_key_i,
  input  entry_t          prev_i,
  input  entry_t          next_i,
  input  logic            next_match_i,
  output entry_t          ent_o,
  output logic            match_o
);

  logic              valid_q, valid_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ColorW-1:0] color_q, color_d;
  logic              match_q, match_d;
  entry_t            nxt;

  always_comb begin
    nxt = '{valid: valid_q, key: key_q, color: color_q};
    if (ctrl_i.upd) begin
      if (ctrl_i.ins) begin
        nxt = prev_i;
      end else if (ctrl_i.hit) begin
        // move the matching entry one place forward, the front one stays
        if (match_q && !FRONT) begin
          nxt = prev_i;
        end else if (next_match_i) begin
          nxt = next_i;
        end
      end
    end
    valid_d = nxt.valid;
    key_d   = nxt.key;
    color_d = nxt.color;
  end

  assign match_d = ctrl_i.cmp_en ? (valid_q && (key_q == req_key_i)) : match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    color_q <= color_d;
  end

  assign ent_o   = '{valid: valid_q, key: key_q, color: color_q};
  assign match_o = match_q;

endmodule

[rtl/socc_result.sv]
// Result encoder: folds the one-hot match row into hit, position and payload,
// and decides insert and drop. Depends on socc_pkg.
module socc_result import socc_pkg::*; #(
  parameter int unsigned CACHE_SLOTS = CacheSlotsDef
) (
  input  logic [CACHE_SLOTS-1:0] match_i,
  input  entry_t                 ent_i [CACHE_SLOTS],
  input  logic                   cmd_i,
  input  logic [ColorW-1:0]      value_i,
  output res_t                   res_o
);

  localparam int unsigned IdxW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int unsigned ExtW = (IdxW > PosW) ? IdxW : PosW;

  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   idx_adj;
  logic [ExtW-1:0]   pos_ext;
  logic [ColorW-1:0] hit_color;
  logic              hit;
  logic              ins;
  logic              full;

  // keys are unique, so the match row is one-hot and an OR tree selects
  always_comb begin
    idx       = '0;
    hit_color = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (match_i[i]) begin
        idx       = idx | IdxW'(i);
        hit_color = hit_color | ent_i[i].color;
      end
    end
  end

  assign hit     = |match_i;
  assign ins     = !hit && cmd_i;
  assign full    = ent_i[CACHE_SLOTS-1].valid;
  assign idx_adj = (idx != '0) ? idx - IdxW'(1) : idx;
  assign pos_ext = ExtW'(idx_adj);

  always_comb begin
    res_o = '0;
    if (hit) begin
      res_o.hit       = 1'b1;
      res_o.position  = pos_ext[PosW-1:0];
      res_o.color_out = hit_color;
    end else if (ins) begin
      res_o.inserted  = 1'b1;
      res_o.color_out = value_i;
      if (full) begin
        res_o.dropped       = 1'b1;
        res_o.dropped_color = ent_i[CACHE_SLOTS-1].color;
      end
    end
  end

endmodule

[tb/tb_self_organizing_color_cache_top.sv]
// Self-checking testbench for self_organizing_color_cache_top: drives probe and insert
// transactions, mirrors the transpose-on-hit cache in a small class, checks every result.
// Depends on socc_pkg and the RTL top level only.
module tb_self_organizing_color_cache_top import socc_pkg::*; ();

  typedef enum logic {CmdProbe = 1'b0, CmdInsert = 1'b1} cmd_e;
  typedef enum logic [1:0] {KindBack = 2'd0, KindFore = 2'd1, KindCursor = 2'd2,
                            KindOdd = 2'd3} kind_e;

  typedef struct {
    cmd_e        cmd;
    kind_e       kind;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [15:0] attr;
    logic [7:0]  win;
    logic [63:0] value;
  } color_req_t;

  localparam int unsigned RandomReqs = 1100;
  localparam int unsigned PoolSize   = 28;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainWait  = 10;

  // Mirror of the ordered cache plus the queue of results still owed by the block.
  class color_cache_mirror;
    logic [KeyW-1:0]   keys   [CacheSlotsDef];
    logic [ColorW-1:0] colors [CacheSlotsDef];
    int unsigned       fill;
    res_t              owed[$];
    int unsigned       mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted request to the mirror and queue the result it must produce.
    function void accept_request(color_req_t r);
      logic [KeyW-1:0]   key;
      logic [31:0]       sel;
      logic [KeyW-1:0]   tk;
      logic [ColorW-1:0] tc;
      int                idx;
      res_t              res;
      sel = (r.kind == KindFore) ? r.fg : r.bg;
      key = (32'(r.kind) << 16) | ({r.win, 24'h0} & WinByteMask) | {8'h0, r.attr, 8'h0} | sel;
      idx = -1;
      for (int i = 0; i < fill; i++) begin
        if (idx < 0 && keys[i] == key) idx = i;
      end
      res = '0;
      if (idx >= 0) begin
        if (idx > 0) begin
          tk = keys[idx];
          tc = colors[idx];
          keys[idx] = keys[idx-1];
          colors[idx] = colors[idx-1];
          keys[idx-1] = tk;
          colors[idx-1] = tc;
          idx--;
        end
        res.hit = 1'b1;
        res.position = idx[PosW-1:0];
        res.color_out = colors[idx];
      end else if (r.cmd == CmdInsert) begin
        if (fill == CacheSlotsDef) begin
          res.dropped = 1'b1;
          res.dropped_color = colors[CacheSlotsDef-1];
        end else begin
          fill++;
        end
        for (int i = CacheSlotsDef - 1; i > 0; i--) begin
          keys[i] = keys[i-1];
          colors[i] = colors[i-1];
        end
        keys[0] = key;
        colors[0] = r.value;
        res.inserted = 1'b1;
        res.color_out = r.value;
      end
      owed.push_back(res);
    endfunction

    function void compare_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request outstanding", $realtime);
        return;
      end
      want = owed.pop_front();
      if (got.hit !== want.hit || got.position !== want.position ||
          got.color_out !== want.color_out || got.inserted !== want.inserted ||
          got.dropped !== want.dropped || got.dropped_color !== want.dropped_color) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp hit=%0b pos=%0d col=%h ins=%0b drp=%0b dcol=%h",
                   $realtime, want.hit, want.position, want.color_out, want.inserted,
                   want.dropped, want.dropped_color, "\n           act hit=%0b pos=%0d",
                   got.hit, got.position, " col=%h ins=%0b drp=%0b dcol=%h",
                   got.color_out, got.inserted, got.dropped, got.dropped_color);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        command_i     = 1'b0;
  logic [1:0]  kind_i        = 2'd0;
  logic [31:0] fg_color_i    = '0;
  logic [31:0] bg_color_i    = '0;
  logic [15:0] attr_mode_i   = '0;
  logic [7:0]  win_mode_i    = '0;
  logic [63:0] color_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        hit_o;
  logic [3:0]  position_o;
  logic [63:0] color_out_o;
  logic        inserted_o;
  logic        dropped_o;
  logic [63:0] dropped_color_o;

  color_cache_mirror cache_mirror = new();

  // Shared knobs: quiet turns off random idling on both sides, hold_request asks
  // the result side for one long hold-off.
  bit          quiet        = 1'b0;
  bit          hold_request = 1'b0;
  color_req_t  pool[PoolSize];

  self_organizing_color_cache_top dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .command_i, .kind_i, .fg_color_i, .bg_color_i,
    .attr_mode_i, .win_mode_i, .color_value_i,
    .out_valid_o, .out_ready_i,
    .hit_o, .position_o, .color_out_o, .inserted_o, .dropped_o, .dropped_color_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request: idle at random first, then hold valid and the payload
  // steady until the transaction is taken, and log it in the mirror.
  task automatic offer_request(color_req_t r);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= r.cmd;
    kind_i        <= r.kind;
    fg_color_i    <= r.fg;
    bg_color_i    <= r.bg;
    attr_mode_i   <= r.attr;
    win_mode_i    <= r.win;
    color_value_i <= r.value;
    do @(posedge clk_i); while (!in_ready_o);
    cache_mirror.accept_request(r);
  endtask

  task automatic offer_fields(cmd_e cmd, kind_e kind, logic [31:0] fg, logic [31:0] bg,
                              logic [15:0] attr, logic [7:0] win, logic [63:0] value);
    color_req_t r;
    r = '{cmd: cmd, kind: kind, fg: fg, bg: bg, attr: attr, win: win, value: value};
    offer_request(r);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (cache_mirror.owed.size() != 0);
  endtask

  function automatic color_req_t fresh_request();
    color_req_t r;
    r.cmd   = cmd_e'($urandom_range(1));
    r.kind  = kind_e'($urandom_range(3));
    r.fg    = $urandom;
    r.bg    = $urandom;
    r.attr  = 16'($urandom);
    r.win   = 8'($urandom);
    r.value = {$urandom, $urandom};
    return r;
  endfunction

  // Result side: check each accepted result, then pick ready for the next cycle.
  initial begin : result_sink
    res_t        seen;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        seen.hit           = hit_o;
        seen.position      = position_o;
        seen.color_out     = color_out_o;
        seen.inserted      = inserted_o;
        seen.dropped       = dropped_o;
        seen.dropped_color = dropped_color_o;
        cache_mirror.compare_result(seen);
      end
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 13);
      end
    end
  end

  // Watchdog: stop the run when no transaction moves on either side for too long.
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
      else stalled++;
    end
    $display("tb_self_organizing_color_cache_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    color_req_t r;
    int unsigned pick;
    int unsigned span;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Probe-only miss on an empty cache leaves it untouched.
    offer_fields(CmdProbe, KindBack, 32'h0, 32'h1234_5678, 16'h00ff, 8'h01, '1);
    // Extremes: all-zero key (foreground word ignored) and all-ones key via kind 3.
    offer_fields(CmdInsert, KindBack, '1, '0, '0, '0, '0);
    offer_fields(CmdInsert, KindOdd, '0, '1, '1, '1, '1);
    // Hit at the front: no swap, position 0.
    offer_fields(CmdProbe, KindOdd, '0, '1, '1, '1, 64'h0);
    // Hit one back with insert command: swap forward, no insert.
    offer_fields(CmdInsert, KindBack, 32'hdead_beef, '0, '0, '0, 64'h5555);
    offer_fields(CmdInsert, KindFore, 32'h1234_5678, '0, 16'h0, 8'h00, 64'h1111_2222_3333_4444);
    offer_fields(CmdInsert, KindCursor, '1, 32'ha5a5_a5a5, 16'h5a5a, 8'h3c, 64'hcafe);
    // Fill past capacity so the last valid entry falls out three times.
    for (int i = 0; i < 15; i++) begin
      offer_fields(CmdInsert, kind_e'(i % 4), 32'h1000_0000 + i, 32'h1000_0000 + i,
                   16'(i), 8'(i + 1), {32'(i), 32'hf0f0_0000 + i});
    end
    // Probe an entry deep in the list, then a key that has been pushed out.
    offer_fields(CmdProbe, KindOdd, 32'h1000_0003, 32'h1000_0003, 16'd3, 8'd4, '0);
    offer_fields(CmdProbe, KindBack, '1, '0, '0, '0, '0);
    drain_results();

    // Random part: most requests revisit a pool of keys so hits, swaps and
    // drops keep happening; the rest are fresh keys or plain noise.
    for (int p = 0; p < PoolSize; p++) begin
      pool[p] = fresh_request();
      pool[p].cmd = CmdInsert;
    end
    for (int n = 0; n < RandomReqs; n++) begin
      quiet = (n >= 300 && n < 500);
      if (n == 200 || n == 800) hold_request = 1'b1;
      if (n == 600) drain_results();
      // Small working set first (mostly hits), then one that overflows the cache.
      span = (n < 450) ? 12 : PoolSize;
      pick = $urandom_range(99);
      if (pick < 70) begin
        r = pool[$urandom_range(span - 1)];
        r.cmd = ($urandom_range(3) != 0) ? CmdInsert : CmdProbe;
        r.value = {$urandom, $urandom};
        // Rewrite the color word the key does not use; the lookup must not care.
        if (r.kind == KindFore) r.bg = $urandom;
        else r.fg = $urandom;
      end else if (pick < 85) begin
        r = fresh_request();
        r.cmd = CmdInsert;
        pool[$urandom_range(span - 1)] = r;
      end else begin
        r = fresh_request();
      end
      offer_request(r);
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    // Wait for every owed result, then keep watching to catch strays.
    while (cache_mirror.owed.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (cache_mirror.mismatches == 0 && cache_mirror.owed.size() == 0) begin
      $display("tb_self_organizing_color_cache_top: done, clean");
    end else begin
      $display("tb_self_organizing_color_cache_top: done, errors");
    end
    $finish;
  end

endmodule

[self_organizing_color_cache_top.f]
rtl/socc_pkg.sv
rtl/socc_cell.sv
rtl/socc_result.sv
rtl/self_organizing_color_cache_top.sv
tb/tb_self_organizing_color_cache_top.sv
